[rtl/nbcr_pkg.sv]
// Shared types and constants for the netboot command responder.
package nbcr_pkg;

    localparam int WORD_W = 32;
    localparam int LEN_W  = 11;
    localparam int KIND_W = 3;

    // Message kinds as decoded from the header
    typedef enum logic [KIND_W-1:0] {
        KIND_COMMAND   = 3'd0,
        KIND_SEND_FILE = 3'd1,
        KIND_DATA      = 3'd2,
        KIND_LAST_DATA = 3'd3,
        KIND_BOOT      = 3'd4,
        KIND_QUERY     = 3'd5,
        KIND_UNKNOWN   = 3'd6
    } msg_kind_t;

    // Stored kind before any message was recorded; also the raw code folded to unknown
    localparam logic [KIND_W-1:0] KIND_NONE = 3'd7;

    typedef enum logic [KIND_W-1:0] {
        REPLY_ACK           = 3'd0,
        REPLY_FILE_RECEIVED = 3'd1,
        REPLY_BAD_FILE      = 3'd2,
        REPLY_TOO_LARGE     = 3'd3,
        REPLY_BAD_COMMAND   = 3'd4,
        REPLY_QUERY_ACK     = 3'd5
    } reply_kind_t;

    // Classified header passed from front to back
    typedef struct packed {
        msg_kind_t         kind;
        logic [WORD_W-1:0] cookie;
        logic [WORD_W-1:0] arg;
        logic [LEN_W-1:0]  payload_len;
        logic              has_payload;
        logic              file_accepted;
        logic [WORD_W-1:0] file_capacity;
    } cmd_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port: one 32-bit register per word, word index in paddr[2]
    localparam int APB_ADDR_W = 3;
    localparam logic REG_PROTOCOL_VERSION = 1'b0;

endpackage

[rtl/nbcr_if.sv]
// Valid/ready channel interfaces for headers in and decisions out.
interface nbcr_in_if;
    logic                          valid;
    logic                          ready;
    logic [nbcr_pkg::KIND_W-1:0]   kind;
    logic [nbcr_pkg::WORD_W-1:0]   cookie;
    logic [nbcr_pkg::WORD_W-1:0]   arg;
    logic [nbcr_pkg::LEN_W-1:0]    payload_len;
    logic                          file_accepted;
    logic [nbcr_pkg::WORD_W-1:0]   file_capacity;

    modport source (
        output valid, kind, cookie, arg, payload_len, file_accepted, file_capacity,
        input  ready
    );
    modport sink (
        input  valid, kind, cookie, arg, payload_len, file_accepted, file_capacity,
        output ready
    );
endinterface

interface nbcr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          send_reply;
    logic [nbcr_pkg::KIND_W-1:0]   reply_kind;
    logic [nbcr_pkg::WORD_W-1:0]   reply_cookie;
    logic [nbcr_pkg::WORD_W-1:0]   reply_arg;
    logic                          write_enable;
    logic [nbcr_pkg::WORD_W-1:0]   write_offset;
    logic [nbcr_pkg::LEN_W-1:0]    write_length;
    logic                          boot_request;

    modport source (
        output valid, send_reply, reply_kind, reply_cookie, reply_arg,
               write_enable, write_offset, write_length, boot_request,
        input  ready
    );
    modport sink (
        input  valid, send_reply, reply_kind, reply_cookie, reply_arg,
               write_enable, write_offset, write_length, boot_request,
        output ready
    );
endinterface

[rtl/nbcr_front.sv]
// Front stage: accept headers, fold the undefined kind, flag empty payloads.
module nbcr_front (
    input  logic            clk,
    input  logic            rst_n,
    nbcr_in_if.sink         req,
    output nbcr_pkg::cmd_t  cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);

    logic            valid_reg;
    logic            valid_next;
    nbcr_pkg::cmd_t  cmd_reg;
    nbcr_pkg::cmd_t  cmd_next;
    logic            take;

    assign req.ready = !valid_reg || cmd_ready;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        cmd_next = cmd_reg;
        if (take)
        begin
            if (req.kind == nbcr_pkg::KIND_NONE)
            begin
                cmd_next.kind = nbcr_pkg::KIND_UNKNOWN;
            end
            else
            begin
                cmd_next.kind = nbcr_pkg::msg_kind_t'(req.kind);
            end
            cmd_next.cookie        = req.cookie;
            cmd_next.arg           = req.arg;
            cmd_next.payload_len   = req.payload_len;
            cmd_next.has_payload   = (req.payload_len != '0);
            cmd_next.file_accepted = req.file_accepted;
            cmd_next.file_capacity = req.file_capacity;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

[rtl/nbcr_queue.sv]
// Short queue of classified headers between front and back.
module nbcr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  nbcr_pkg::cmd_t  push_cmd,
    input  logic            push_valid,
    output logic            push_ready,
    output nbcr_pkg::cmd_t  pop_cmd,
    output logic            pop_valid,
    input  logic            pop_ready
);

    nbcr_pkg::cmd_t                  mem_reg [nbcr_pkg::QUEUE_DEPTH];
    logic [nbcr_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [nbcr_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [nbcr_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [nbcr_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [nbcr_pkg::QCNT_W-1:0]     count_reg;
    logic [nbcr_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != nbcr_pkg::QCNT_W'(nbcr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == nbcr_pkg::QPTR_W'(nbcr_pkg::QUEUE_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == nbcr_pkg::QPTR_W'(nbcr_pkg::QUEUE_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/nbcr_back.sv]
// Back stage: protocol state, repeat detection, decision and output register.
module nbcr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nbcr_pkg::cmd_t               cmd,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic [nbcr_pkg::WORD_W-1:0]  protocol_version,
    nbcr_out_if.source                   rsp
);

    typedef struct packed {
        logic                         send_reply;
        logic [nbcr_pkg::KIND_W-1:0]  reply_kind;
        logic [nbcr_pkg::WORD_W-1:0]  reply_cookie;
        logic [nbcr_pkg::WORD_W-1:0]  reply_arg;
        logic                         write_enable;
        logic [nbcr_pkg::WORD_W-1:0]  write_offset;
        logic [nbcr_pkg::LEN_W-1:0]   write_length;
        logic                         boot_request;
    } result_t;

    logic [nbcr_pkg::WORD_W-1:0]  prev_cookie_reg;
    logic [nbcr_pkg::KIND_W-1:0]  prev_kind_reg;
    logic [nbcr_pkg::WORD_W-1:0]  prev_arg_reg;
    logic [nbcr_pkg::KIND_W-1:0]  prev_reply_kind_reg;
    logic [nbcr_pkg::WORD_W-1:0]  prev_reply_arg_reg;
    logic                         file_open_reg;
    logic                         file_open_next;
    logic [nbcr_pkg::WORD_W-1:0]  file_offset_reg;
    logic [nbcr_pkg::WORD_W-1:0]  file_offset_next;
    logic [nbcr_pkg::WORD_W-1:0]  file_size_reg;
    logic [nbcr_pkg::WORD_W-1:0]  file_size_next;
    logic                         res_valid_reg;
    logic                         res_valid_next;
    result_t                      res_reg;
    result_t                      res_next;

    logic                         pop;
    logic                         is_repeat;
    logic                         record;
    logic                         send;
    logic [nbcr_pkg::KIND_W-1:0]  akind;
    logic [nbcr_pkg::WORD_W-1:0]  aarg;
    logic [nbcr_pkg::WORD_W:0]    end_offset;

    assign cmd_ready = !res_valid_reg || rsp.ready;
    assign pop       = cmd_valid && cmd_ready;

    assign is_repeat = (cmd.cookie == prev_cookie_reg)
                    && (cmd.kind == prev_kind_reg)
                    && (cmd.arg == prev_arg_reg);
    // Widened so the capacity check sees no wrap
    assign end_offset = {1'b0, file_offset_reg}
                      + (nbcr_pkg::WORD_W + 1)'(cmd.payload_len);

    always_comb
    begin
        record           = 1'b0;
        send             = 1'b0;
        akind            = nbcr_pkg::REPLY_ACK;
        aarg             = '0;
        res_next         = '0;
        file_open_next   = file_open_reg;
        file_offset_next = file_offset_reg;
        file_size_next   = file_size_reg;
        if (is_repeat)
        begin
            send                  = 1'b1;
            res_next.reply_kind   = prev_reply_kind_reg;
            res_next.reply_cookie = prev_cookie_reg;
            res_next.reply_arg    = prev_reply_arg_reg;
        end
        else
        begin
            case (cmd.kind)
                nbcr_pkg::KIND_COMMAND:
                begin
                    record = cmd.has_payload;
                    send   = cmd.has_payload;
                end
                nbcr_pkg::KIND_SEND_FILE:
                begin
                    if (cmd.has_payload)
                    begin
                        record         = 1'b1;
                        send           = 1'b1;
                        file_open_next = cmd.file_accepted;
                        if (cmd.file_accepted)
                        begin
                            file_offset_next = '0;
                            file_size_next   = cmd.file_capacity;
                            aarg             = cmd.arg;
                        end
                        else
                        begin
                            akind = nbcr_pkg::REPLY_BAD_FILE;
                        end
                    end
                end
                nbcr_pkg::KIND_DATA, nbcr_pkg::KIND_LAST_DATA:
                begin
                    if (file_open_reg)
                    begin
                        record = 1'b1;
                        send   = 1'b1;
                        if (cmd.arg != file_offset_reg)
                        begin
                            aarg = file_offset_reg;
                        end
                        else if (end_offset > {1'b0, file_size_reg})
                        begin
                            akind = nbcr_pkg::REPLY_TOO_LARGE;
                            aarg  = cmd.arg;
                        end
                        else
                        begin
                            res_next.write_enable = 1'b1;
                            res_next.write_offset = file_offset_reg;
                            res_next.write_length = cmd.payload_len;
                            file_offset_next      = end_offset[nbcr_pkg::WORD_W-1:0];
                            // Plain data records an ack but stays silent
                            if (cmd.kind == nbcr_pkg::KIND_LAST_DATA)
                            begin
                                akind = nbcr_pkg::REPLY_FILE_RECEIVED;
                            end
                            else
                            begin
                                send = 1'b0;
                            end
                        end
                    end
                end
                nbcr_pkg::KIND_BOOT:
                begin
                    record                = 1'b1;
                    send                  = 1'b1;
                    res_next.boot_request = 1'b1;
                end
                nbcr_pkg::KIND_QUERY:
                begin
                    send                  = 1'b1;
                    res_next.reply_kind   = nbcr_pkg::REPLY_QUERY_ACK;
                    res_next.reply_cookie = cmd.cookie;
                    res_next.reply_arg    = protocol_version;
                end
                default:
                begin
                    record = 1'b1;
                    send   = 1'b1;
                    akind  = nbcr_pkg::REPLY_BAD_COMMAND;
                end
            endcase
            if (record && send)
            begin
                res_next.reply_kind   = akind;
                res_next.reply_cookie = cmd.cookie;
                res_next.reply_arg    = aarg;
            end
        end
        res_next.send_reply = send;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cookie_reg     <= '0;
            prev_kind_reg       <= nbcr_pkg::KIND_NONE;
            prev_arg_reg        <= '0;
            prev_reply_kind_reg <= nbcr_pkg::REPLY_ACK;
            prev_reply_arg_reg  <= '0;
            file_open_reg       <= 1'b0;
            file_offset_reg     <= '0;
            file_size_reg       <= '0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                file_open_reg   <= file_open_next;
                file_offset_reg <= file_offset_next;
                file_size_reg   <= file_size_next;
                if (record)
                begin
                    prev_cookie_reg     <= cmd.cookie;
                    prev_kind_reg       <= cmd.kind;
                    prev_arg_reg        <= cmd.arg;
                    prev_reply_kind_reg <= akind;
                    prev_reply_arg_reg  <= aarg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid        = res_valid_reg;
    assign rsp.send_reply   = res_reg.send_reply;
    assign rsp.reply_kind   = res_reg.reply_kind;
    assign rsp.reply_cookie = res_reg.reply_cookie;
    assign rsp.reply_arg    = res_reg.reply_arg;
    assign rsp.write_enable = res_reg.write_enable;
    assign rsp.write_offset = res_reg.write_offset;
    assign rsp.write_length = res_reg.write_length;
    assign rsp.boot_request = res_reg.boot_request;

    a_repeat_keeps_file: assert property (@(posedge clk) disable iff (!rst_n)
        pop && is_repeat |=> $stable(file_open_reg) && $stable(file_offset_reg))
        else $error("repeated header changed the file state");

    a_copy_advances_offset: assert property (@(posedge clk) disable iff (!rst_n)
        pop && res_next.write_enable |=>
            file_offset_reg == $past(file_offset_reg)
                + nbcr_pkg::WORD_W'($past(cmd.payload_len)))
        else $error("accepted chunk did not advance the offset by its length");

    a_query_not_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !is_repeat && cmd.kind == nbcr_pkg::KIND_QUERY |=> $stable(prev_kind_reg))
        else $error("query was recorded");

    a_copy_not_boot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.write_enable |-> !res_reg.boot_request)
        else $error("copy and boot request in the same item");

endmodule

[rtl/netboot_command_responder.sv]
// Top level: front stage, header queue, back stage and configuration register.
// Path: a header goes from the front register through the queue to the output register.
// Unless stalled, one header per cycle; the back stage decides one queued item a cycle.
// Either side may stall on its own; the queue and output register absorb the difference.
// Reset (rst_n low, asynchronous) clears protocol state, queue and output valid;
// the version register reads zero. No clearing pass follows reset.
module netboot_command_responder (
    input  logic                              clk,
    input  logic                              rst_n,
    nbcr_in_if.sink                           req,
    nbcr_out_if.source                        rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nbcr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nbcr_pkg::WORD_W-1:0]       pwdata,
    output logic [nbcr_pkg::WORD_W-1:0]       prdata,
    output logic                              pready
);

    logic [nbcr_pkg::WORD_W-1:0]  protocol_version_reg;
    logic [nbcr_pkg::WORD_W-1:0]  protocol_version_next;
    logic                         cfg_write;
    nbcr_pkg::cmd_t               front_cmd;
    logic                         front_valid;
    logic                         front_ready;
    nbcr_pkg::cmd_t               back_cmd;
    logic                         back_valid;
    logic                         back_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == nbcr_pkg::REG_PROTOCOL_VERSION);

    always_comb
    begin
        protocol_version_next = protocol_version_reg;
        if (cfg_write)
        begin
            protocol_version_next = pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == nbcr_pkg::REG_PROTOCOL_VERSION)
        begin
            prdata = protocol_version_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_version_reg <= '0;
        end
        else
        begin
            protocol_version_reg <= protocol_version_next;
        end
    end

    nbcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    nbcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    nbcr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (back_cmd),
        .cmd_valid        (back_valid),
        .cmd_ready        (back_ready),
        .protocol_version (protocol_version_reg),
        .rsp              (rsp)
    );

endmodule
